// ----- src/sorted_event_queue_assert.svh -----
// Assertion macros used by the sorted event queue top level.
`ifndef SORTED_EVENT_QUEUE_ASSERT_SVH
`define SORTED_EVENT_QUEUE_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Checked on every rising clock edge outside reset.
`define SEQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every rising clock edge, also during reset.
`define SEQ_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SEQ_ASSERT(label, prop, msg)
`define SEQ_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// ----- src/seq_pkg.sv -----
// Types and codes shared by the sorted event queue modules.
package seq_pkg;

    typedef enum logic
    {
        FUNC_INSERT = 1'b0,
        FUNC_POP    = 1'b1
    } func_t;

    typedef enum logic [1:0]
    {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    typedef struct packed
    {
        func_t       func;
        logic        event_kind;
        logic [31:0] event_time;
    } req_t;

    typedef struct packed
    {
        logic        popped_valid;
        logic        popped_kind;
        logic [31:0] popped_time;
        status_t     status;
        logic [4:0]  occupancy;
    } rsp_t;

    // Operation broadcast to every cell of the chain.
    typedef struct packed
    {
        logic shift_in;
        logic shift_out;
    } cell_op_t;

endpackage

// ----- src/seq_cell.sv -----
// One storage cell of the sorted chain: holds one event and trades it with its neighbors.
module seq_cell #(
    parameter int IDX       = 0,
    parameter int TIME_BITS = 32,
    parameter int CNT_W     = 5
) (
    input  logic                 clk,
    input  seq_pkg::cell_op_t    op,
    input  logic [CNT_W-1:0]     count,
    input  logic [TIME_BITS-1:0] new_time,
    input  logic                 new_kind,
    input  logic                 left_keep,
    input  logic [TIME_BITS-1:0] left_time,
    input  logic                 left_kind,
    input  logic [TIME_BITS-1:0] right_time,
    input  logic                 right_kind,
    output logic                 keep,
    output logic [TIME_BITS-1:0] time_q,
    output logic                 kind_q
);

    logic [TIME_BITS-1:0] time_reg;
    logic [TIME_BITS-1:0] time_next;
    logic                 kind_reg;
    logic                 kind_next;
    logic                 occupied;

    // The cell holds a live event when its position lies below the fill count.
    assign occupied = (CNT_W'(IDX) < count);
    // A live event not later than the new one stays ahead of it.
    assign keep = occupied && (time_reg <= new_time);

    always_comb
    begin
        time_next = time_reg;
        kind_next = kind_reg;
        if (op.shift_in)
        begin
            if (!keep)
            begin
                if (left_keep)
                begin
                    time_next = new_time;
                    kind_next = new_kind;
                end
                else
                begin
                    time_next = left_time;
                    kind_next = left_kind;
                end
            end
        end
        else if (op.shift_out)
        begin
            time_next = right_time;
            kind_next = right_kind;
        end
    end

    always_ff @(posedge clk)
    begin
        time_reg <= time_next;
        kind_reg <= kind_next;
    end

    assign time_q = time_reg;
    assign kind_q = kind_reg;

endmodule

// ----- src/sorted_event_queue.sv -----
// Top level of the sorted event queue: a chain of cells kept in ascending time order.
//
//  Channel  Handshake            Payload           Direction
//  request  req_valid/req_stall  req (req_t)       into the block
//  response rsp_valid/rsp_stall  rsp (rsp_t)       out of the block
//
// Every request (insert or pop) is served by the whole chain: all cells compare their
// stored time with the new one in parallel and shift by one place in the same edge.
// Each request yields one response, registered; it appears the cycle after acceptance.
// A new request is taken while the response register is empty or being drained, so
// with no downstream stall the block sustains one request per cycle.
// Reset clears the fill count and the response valid; the cell contents need no reset.
// While rsp_stall holds a pending response, req_stall is raised and nothing moves.
`include "sorted_event_queue_assert.svh"

module sorted_event_queue #(
    parameter int QUEUE_DEPTH = 16,
    parameter int TIME_BITS   = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  seq_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output seq_pkg::rsp_t rsp
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Fill count: cells below this index hold live events, in time order.
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic                 rsp_valid_reg;
    logic                 rsp_valid_next;
    seq_pkg::rsp_t        rsp_reg;
    seq_pkg::rsp_t        rsp_next;

    logic                 accept;
    logic                 is_empty;
    logic                 is_full;
    logic [TIME_BITS-1:0] new_time;
    seq_pkg::cell_op_t    op;

    logic [TIME_BITS-1:0] time_q [QUEUE_DEPTH];
    logic                 kind_q [QUEUE_DEPTH];
    logic                 keep   [QUEUE_DEPTH];

    // The response register frees up either when empty or when its response leaves now.
    assign req_stall = rsp_valid_reg && rsp_stall;
    assign accept    = req_valid && !req_stall;

    assign is_empty = (count_reg == '0);
    assign is_full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    // Incoming ticks are taken modulo 2^TIME_BITS.
    assign new_time = TIME_BITS'(req.event_time);

    // Dropped inserts and pops on an empty queue leave the chain untouched.
    assign op.shift_in  = accept && (req.func == seq_pkg::FUNC_INSERT) && !is_full;
    assign op.shift_out = accept && (req.func == seq_pkg::FUNC_POP) && !is_empty;

    // The chain. Cell zero holds the earliest event. On an insert the new event lands
    // in the first cell whose left neighbor keeps its place and which does not; every
    // later cell takes its left neighbor's event. On a pop every cell takes its right
    // neighbor's event; the last cell's content then lies beyond the count.
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        logic                 left_keep;
        logic [TIME_BITS-1:0] left_time;
        logic                 left_kind;
        logic [TIME_BITS-1:0] right_time;
        logic                 right_kind;

        if (i == 0)
        begin : g_first
            assign left_keep = 1'b1;
            assign left_time = new_time;
            assign left_kind = req.event_kind;
        end
        else
        begin : g_inner
            assign left_keep = keep[i-1];
            assign left_time = time_q[i-1];
            assign left_kind = kind_q[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_last
            assign right_time = time_q[i];
            assign right_kind = kind_q[i];
        end
        else
        begin : g_mid
            assign right_time = time_q[i+1];
            assign right_kind = kind_q[i+1];
        end

        seq_cell #(
            .IDX       (i),
            .TIME_BITS (TIME_BITS),
            .CNT_W     (CNT_W)
        ) u_cell (
            .clk        (clk),
            .op         (op),
            .count      (count_reg),
            .new_time   (new_time),
            .new_kind   (req.event_kind),
            .left_keep  (left_keep),
            .left_time  (left_time),
            .left_kind  (left_kind),
            .right_time (right_time),
            .right_kind (right_kind),
            .keep       (keep[i]),
            .time_q     (time_q[i]),
            .kind_q     (kind_q[i])
        );
    end

    // Count update and response formation.
    always_comb
    begin
        count_next = count_reg;
        if (op.shift_in)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (op.shift_out)
        begin
            count_next = count_reg - CNT_W'(1);
        end

        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        if (accept)
        begin
            rsp_valid_next        = 1'b1;
            rsp_next.popped_valid = op.shift_out;
            rsp_next.popped_kind  = op.shift_out ? kind_q[0] : 1'b0;
            rsp_next.popped_time  = op.shift_out ? 32'(time_q[0]) : 32'd0;
            rsp_next.status       = seq_pkg::STATUS_OK;
            if ((req.func == seq_pkg::FUNC_POP) && is_empty)
            begin
                rsp_next.status = seq_pkg::STATUS_EMPTY;
            end
            else if ((req.func == seq_pkg::FUNC_INSERT) && is_full)
            begin
                rsp_next.status = seq_pkg::STATUS_FULL;
            end
            // Occupancy is reported modulo 32 for deep queues.
            rsp_next.occupancy = 5'(count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // The response payload needs no reset; it is only looked at while valid.
    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `SEQ_ASSERT_ALWAYS(a_count_bound, count_reg <= CNT_W'(QUEUE_DEPTH), "fill count beyond depth")
    `SEQ_ASSERT(a_pop_returns, (accept && (req.func == seq_pkg::FUNC_POP) && !is_empty) |=> (rsp_valid_reg && rsp_reg.popped_valid), "pop of a live event returned nothing")
    `SEQ_ASSERT(a_head_order, (count_reg >= CNT_W'(2)) |-> (time_q[0] <= time_q[1]), "head of chain out of time order")
    `SEQ_ASSERT(a_full_holds, (accept && (req.func == seq_pkg::FUNC_INSERT) && is_full) |=> (count_reg == CNT_W'(QUEUE_DEPTH)), "dropped insert changed the fill count")

endmodule
